/* sv/pcfs_pkg.sv */
`default_nettype none

package pcfs_pkg;

    // default sizing
    localparam int NUM_COLORS_DEF = 256;
    localparam int COUNT_BITS_DEF = 24;

    // request and result field widths
    localparam int CMD_W        = 2;
    localparam int PAGE_W       = 24;
    localparam int LIST_INDEX_W = 8;
    localparam int LIST_COUNT_W = 24;
    localparam int SKIPS_W      = 32;
    localparam int UNDERFLOW_W  = 1;

    // stream bus widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = LIST_INDEX_W + LIST_COUNT_W + SKIPS_W;
    localparam int M_TUSER_W = UNDERFLOW_W;

    // configuration registers
    localparam int CFG_IDX_W   = 1;
    localparam int LOOKAHEAD_W = 8;
    localparam int CFG_DATA_W  = LOOKAHEAD_W;

    localparam logic [CFG_IDX_W-1:0] REG_COLORING_EN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD   = 1'b1;

    localparam logic                   COLORING_EN_RST = 1'b1;
    localparam logic [LOOKAHEAD_W-1:0] LOOKAHEAD_RST   = 8'd100;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SELECT = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_RD,
        S_UPD,
        S_SCAN_INIT,
        S_SCAN,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic load_req;
        logic mod_step;
        logic rd_color;
        logic upd;
        logic scan_init;
        logic scan_step;
        logic scan_finish;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic mod_done;
        logic coloring_en;
        logic scan_last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

/* sv/pcfs_ram.sv */
`default_nettype none

module pcfs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/pcfs_ctrl.sv */
`default_nettype none

module pcfs_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire pcfs_pkg::t_cmd     i_in_cmd,
    output logic                    o_in_ready,
    input  wire pcfs_pkg::t_dp_stat i_stat,
    output pcfs_pkg::t_dp_cmd       o_cmd
);

    import pcfs_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    unique case (i_in_cmd) inside
                        CMD_ADD, CMD_REMOVE: n_state = S_MOD;
                        CMD_SELECT:          n_state = i_stat.coloring_en ? S_SCAN_INIT : S_RD;
                        default:             n_state = S_IDLE;
                    endcase
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_done) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_color = 1'b1;
                n_state        = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_OUT;
            end
            S_SCAN_INIT: begin
                o_cmd.scan_init = 1'b1;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    o_cmd.scan_finish = 1'b1;
                    n_state           = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

endmodule

`default_nettype wire

/* sv/pcfs_dp.sv */
`default_nettype none

module pcfs_dp #(
    parameter int NUM_COLORS = pcfs_pkg::NUM_COLORS_DEF,
    parameter int COUNT_BITS = pcfs_pkg::COUNT_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [pcfs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [pcfs_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic [pcfs_pkg::S_TDATA_W-1:0]  i_in_tdata,
    input  wire logic [pcfs_pkg::S_TUSER_W-1:0]  i_in_tuser,
    input  wire pcfs_pkg::t_dp_cmd               i_cmd,
    output pcfs_pkg::t_dp_stat                   o_stat,
    input  wire logic                            i_out_ready,
    output logic                                 o_out_valid,
    output logic      [pcfs_pkg::M_TDATA_W-1:0]  o_out_tdata,
    output logic      [pcfs_pkg::M_TUSER_W-1:0]  o_out_tuser
);

    import pcfs_pkg::*;

    localparam int CW    = $clog2(NUM_COLORS);
    localparam int LW    = $clog2(NUM_COLORS + 1);
    localparam int CMP_W = LOOKAHEAD_W + 1;

    localparam logic [CW-1:0]         LAST_COLOR = CW'(NUM_COLORS - 1);
    localparam logic [LW-1:0]         NUM_LOOKS  = LW'(NUM_COLORS);
    localparam logic [COUNT_BITS-1:0] CNT_MAX    = '1;

    function automatic logic [CW-1:0] next_color(input logic [CW-1:0] c);
        return (c == LAST_COLOR) ? '0 : c + CW'(1);
    endfunction

    // configuration
    logic                   r_coloring_en;
    logic [LOOKAHEAD_W-1:0] r_lookahead;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coloring_en <= COLORING_EN_RST;
            r_lookahead   <= LOOKAHEAD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_COLORING_EN: r_coloring_en <= i_cfg_wdata[0];
                REG_LOOKAHEAD:   r_lookahead   <= i_cfg_wdata[LOOKAHEAD_W-1:0];
                default: ;
            endcase
        end
    end

    // request
    t_cmd r_cmd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_cmd <= t_cmd'(i_in_tuser);
        end
    end

    // page colour: mask, or a reciprocal multiplication over three steps
    logic [CW-1:0] w_page_color;
    logic          w_mod_done;

    if ((NUM_COLORS & (NUM_COLORS - 1)) == 0) begin : g_pow2
        logic [PAGE_W-1:0] r_page;

        always_ff @(posedge i_clk) begin
            if (i_cmd.load_req) begin
                r_page <= i_in_tdata[PAGE_W-1:0];
            end
        end

        assign w_page_color = r_page[CW-1:0];
        assign w_mod_done   = 1'b1;
    end else begin : g_mod
        // quotient estimate is exact or one short, so one subtract corrects the remainder
        localparam longint            RECIP_L = (longint'(1) << PAGE_W) / longint'(NUM_COLORS);
        localparam logic [PAGE_W-1:0] RECIP   = PAGE_W'(RECIP_L);
        localparam logic [PAGE_W-1:0] NC_PG   = PAGE_W'(NUM_COLORS);
        localparam logic [CW:0]       NC_EXT  = (CW + 1)'(NUM_COLORS);
        localparam logic [1:0]        MSTEPS  = 2'd3;

        logic [PAGE_W-1:0]   r_page;
        logic [2*PAGE_W-1:0] r_prod;
        logic [PAGE_W-1:0]   r_qn;
        logic [CW-1:0]       r_rem;
        logic [1:0]          r_mcnt;
        logic [PAGE_W-1:0]   w_diff;

        assign w_diff = r_page - r_qn;

        always_ff @(posedge i_clk) begin
            if (i_cmd.load_req) begin
                r_page <= i_in_tdata[PAGE_W-1:0];
            end else if (i_cmd.mod_step && !w_mod_done) begin
                if (r_mcnt == 2'd0) begin
                    r_prod <= (2*PAGE_W)'(r_page) * (2*PAGE_W)'(RECIP);
                end else if (r_mcnt == 2'd1) begin
                    r_qn <= r_prod[2*PAGE_W-1:PAGE_W] * NC_PG;
                end else begin
                    r_rem <= (w_diff[CW:0] >= NC_EXT) ? CW'(w_diff[CW:0] - NC_EXT)
                                                      : w_diff[CW-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mcnt <= '0;
            end else if (i_cmd.load_req) begin
                r_mcnt <= '0;
            end else if (i_cmd.mod_step && !w_mod_done) begin
                r_mcnt <= r_mcnt + 2'd1;
            end
        end

        assign w_page_color = r_rem;
        assign w_mod_done   = (r_mcnt == MSTEPS);
    end

    logic [CW-1:0] w_color;
    assign w_color = r_coloring_en ? w_page_color : '0;

    // count memory and clearing pass
    logic [CW-1:0]         r_clr_addr;
    logic                  w_ram_we;
    logic [CW-1:0]         w_ram_waddr;
    logic [COUNT_BITS-1:0] w_ram_wdata;
    logic                  w_ram_re;
    logic [CW-1:0]         w_ram_raddr;
    logic [COUNT_BITS-1:0] w_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + CW'(1);
        end
    end

    // add / remove update
    logic [COUNT_BITS-1:0] w_upd_cnt;
    logic                  w_upd_we;
    logic                  w_upd_uf;

    always_comb begin
        w_upd_cnt = w_rd;
        w_upd_we  = 1'b0;
        w_upd_uf  = 1'b0;
        case (r_cmd)
            CMD_ADD: begin
                w_upd_we  = 1'b1;
                w_upd_cnt = (w_rd == CNT_MAX) ? w_rd : w_rd + COUNT_BITS'(1);
            end
            CMD_REMOVE: begin
                w_upd_we = 1'b1;
                if (w_rd == '0) begin
                    w_upd_uf = 1'b1;
                end else begin
                    w_upd_cnt = w_rd - COUNT_BITS'(1);
                end
            end
            default: ;
        endcase
    end

    // select scan, one stored count evaluated per cycle
    logic [CW-1:0]         r_last_choice;
    logic [SKIPS_W-1:0]    r_empty_total;
    logic [CW-1:0]         r_eval;
    logic [CW-1:0]         r_best_idx;
    logic [COUNT_BITS-1:0] r_best_val;
    logic [LW-1:0]         r_looks;
    logic [CMP_W-1:0]      r_cmps;

    logic [CW-1:0]         w_start;
    logic                  w_nonzero;
    logic                  w_better;
    logic [CW-1:0]         n_best_idx;
    logic [COUNT_BITS-1:0] n_best_val;
    logic [CMP_W-1:0]      n_cmps;
    logic                  w_scan_last;

    assign w_start     = next_color(r_last_choice);
    assign w_nonzero   = |w_rd;
    assign w_better    = (w_rd > r_best_val);
    assign n_best_idx  = w_better ? r_eval : r_best_idx;
    assign n_best_val  = w_better ? w_rd : r_best_val;
    assign n_cmps      = r_cmps + CMP_W'(w_nonzero);
    assign w_scan_last = ((r_looks + LW'(1)) == NUM_LOOKS) ||
                         (n_cmps > {1'b0, r_lookahead});

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_eval     <= w_start;
            r_best_idx <= w_start;
            r_best_val <= '0;
            r_looks    <= '0;
            r_cmps     <= '0;
        end else if (i_cmd.scan_step) begin
            r_eval     <= next_color(r_eval);
            r_best_idx <= n_best_idx;
            r_best_val <= n_best_val;
            r_looks    <= r_looks + LW'(1);
            r_cmps     <= n_cmps;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_choice <= '0;
            r_empty_total <= '0;
        end else begin
            if (i_cmd.scan_step && !w_nonzero) begin
                r_empty_total <= r_empty_total + SKIPS_W'(1);
            end
            if (i_cmd.scan_finish) begin
                r_last_choice <= n_best_idx;
            end
        end
    end

    // memory ports
    assign w_ram_we    = i_cmd.clr_step || (i_cmd.upd && w_upd_we);
    assign w_ram_waddr = i_cmd.clr_step ? r_clr_addr : w_color;
    assign w_ram_wdata = i_cmd.clr_step ? '0 : w_upd_cnt;
    assign w_ram_re    = i_cmd.rd_color || i_cmd.scan_init || i_cmd.scan_step;
    assign w_ram_raddr = i_cmd.rd_color  ? w_color :
                         i_cmd.scan_init ? w_start : next_color(r_eval);

    pcfs_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_COLORS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_rd)
    );

    // result staging
    logic [CW-1:0]         r_res_idx;
    logic [COUNT_BITS-1:0] r_res_cnt;
    logic                  r_res_uf;

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_res_idx <= w_color;
            r_res_cnt <= w_upd_cnt;
            r_res_uf  <= w_upd_uf;
        end else if (i_cmd.scan_finish) begin
            r_res_idx <= n_best_idx;
            r_res_cnt <= n_best_val;
            r_res_uf  <= 1'b0;
        end
    end

    // output register
    logic [CW+LIST_INDEX_W-1:0]         w_idx_ext;
    logic [COUNT_BITS+LIST_COUNT_W-1:0] w_cnt_ext;
    logic                               r_out_valid;
    logic [M_TDATA_W-1:0]               r_out_tdata;
    logic [M_TUSER_W-1:0]               r_out_tuser;

    assign w_idx_ext = {{LIST_INDEX_W{1'b0}}, r_res_idx};
    assign w_cnt_ext = {{LIST_COUNT_W{1'b0}}, r_res_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_tdata <= {r_empty_total, w_cnt_ext[LIST_COUNT_W-1:0],
                            w_idx_ext[LIST_INDEX_W-1:0]};
            r_out_tuser <= r_res_uf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_tdata = r_out_tdata;
    assign o_out_tuser = r_out_tuser;

    assign o_stat.clr_last    = (r_clr_addr == LAST_COLOR);
    assign o_stat.mod_done    = w_mod_done;
    assign o_stat.coloring_en = r_coloring_en;
    assign o_stat.scan_last   = w_scan_last;
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

/* sv/page_color_freelist_selector.sv */
// Free-page count per cache colour with a round-robin largest-list select. After reset
// the block sweeps its count memory to zero, one colour per cycle, over all NUM_COLORS
// colours (256 by default), and s_axis_tready stays low until the sweep ends; configuration
// writes are taken during the sweep. One request is worked on at a time. Add and remove
// go through colour mask, memory read, update and write, and output load with a power
// of two NUM_COLORS; otherwise the colour comes from a reciprocal multiplication
// (estimate, back-multiply, one corrective subtract) on the 24-bit page number. A select
// with colouring on looks at no more than NUM_COLORS lists; the scan reads one count per
// cycle from the single read port of the count memory. A select with colouring off reads
// only the count of colour 0. A finished result sits in the output register, so the next
// request is taken while it waits; a request whose result finds that register still full
// waits there.
`default_nettype none

module page_color_freelist_selector #(
    parameter int NUM_COLORS = pcfs_pkg::NUM_COLORS_DEF,
    parameter int COUNT_BITS = pcfs_pkg::COUNT_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [pcfs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [pcfs_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // request stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [pcfs_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // page_number[23:0]
    input  wire logic [pcfs_pkg::S_TUSER_W-1:0]  s_axis_tuser,  // cmd[1:0]
    // result stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic      [pcfs_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // list_index[7:0],
                                                                // list_count[31:8],
                                                                // empty_skips[63:32]
    output logic      [pcfs_pkg::M_TUSER_W-1:0]  m_axis_tuser   // underflow[0]
);

    import pcfs_pkg::*;

    // command and status between sequencer and datapath
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    pcfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (t_cmd'(s_axis_tuser)),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // counts, colour divider, scan registers and output register
    pcfs_dp #(
        .NUM_COLORS (NUM_COLORS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_tdata  (s_axis_tdata),
        .i_in_tuser  (s_axis_tuser),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_tdata (m_axis_tdata),
        .o_out_tuser (m_axis_tuser)
    );

endmodule

`default_nettype wire

/* sv/pcfs_checker.sv */
`default_nettype none

module pcfs_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_cfg_we,
    input wire logic [pcfs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input wire logic [pcfs_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic [pcfs_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input wire logic [pcfs_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [pcfs_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input wire logic [pcfs_pkg::M_TUSER_W-1:0]  m_axis_tuser
);

    import pcfs_pkg::*;

    // the clearing pass keeps requests out right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("request taken during the clearing pass");

    // a held result does not change
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // a valid command keeps the block busy for at least the next cycle
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready &&
        (s_axis_tuser == CMD_ADD || s_axis_tuser == CMD_REMOVE ||
         s_axis_tuser == CMD_SELECT) |=> !s_axis_tready)
        else $error("second request taken while one is in progress");

    // an underflow leaves the count at zero
    a_underflow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[LIST_INDEX_W +: LIST_COUNT_W] == '0)
        else $error("underflow reported with a non-zero count");

endmodule

bind page_color_freelist_selector pcfs_checker u_pcfs_checker (.*);

`default_nettype wire
